@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sdec_pkg.sv @@
package sdec_pkg;

  // Default and largest data word width.
  localparam int DATA_BITS_DEF = 8;
  localparam int DATA_BITS_MAX = 8;

  // Parity-check matrix storage.
  localparam int NUM_ROWS  = 8;
  localparam int ROW_W     = 16;
  localparam int REG_IDX_W = $clog2(NUM_ROWS);

  // Payload byte width.
  localparam int BYTE_W = 8;

  // Register port geometry: one 32-bit word per row.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = REG_IDX_W + 2;

  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] h_rows_t;

endpackage

@@ sv/syndrome_double_error_corrector_core.sv @@
// Syndrome decoder for a (2*DATA_BITS, DATA_BITS) block code with a parity-check
// matrix held in eight row registers, correcting up to two bit errors per word.
// A transfer on the input channel is captured in an input register, decoded in one
// pass of parallel syndrome, pair and single-column compares, and held in a result
// register: one word per cycle while the result side does not stall.
// That rate is set by the single decode stage between the two registers. A stall
// on the result side holds the result register and then stalls the input.
// Rewrite the matrix rows only while no word is in flight.
module syndrome_double_error_corrector_core
  import sdec_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [BYTE_W-1:0]     in_parity_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_corrected_byte,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  h_rows_t           h_rows;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic [BYTE_W-1:0] s1_data_r;
  logic [BYTE_W-1:0] s1_par_r;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [BYTE_W-1:0] dec_byte;
  logic              out_adv;
  logic              in_take;

  sdec_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .h_rows  (h_rows)
  );

  sdec_decode #(
    .DATA_BITS (DATA_BITS)
  ) u_dec (
    .h_rows         (h_rows),
    .data_byte      (s1_data_r),
    .parity_byte    (s1_par_r),
    .corrected_byte (dec_byte)
  );

  // The result register moves when it is empty or its transfer completes.
  assign out_adv  = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  // The input register empties into the result register when that one moves,
  // and fills on any input transfer, even while the result side is blocked.
  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (out_adv) begin
      out_vld_nxt = s1_vld_r;
      s1_vld_nxt  = 1'b0;
    end
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_par_r  <= in_parity_byte;
    end
    if (out_adv && s1_vld_r) begin
      out_byte_r <= dec_byte;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_corrected_byte = out_byte_r;

endmodule

@@ sv/sdec_cfg_regs.sv @@
module sdec_cfg_regs
  import sdec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output h_rows_t               h_rows
);

  h_rows_t               h_rows_r;
  h_rows_t               h_rows_nxt;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // A write transfer completes in the access cycle; the port never waits.
  always_comb begin
    h_rows_nxt = h_rows_r;
    if (wr_en) begin
      h_rows_nxt[reg_idx] = pwdata[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_rows_r <= '0;
    end else begin
      h_rows_r <= h_rows_nxt;
    end
  end

  assign prdata = {{(APB_DATA_W-ROW_W){1'b0}}, h_rows_r[reg_idx]};
  assign pready = 1'b1;
  assign h_rows = h_rows_r;

endmodule

@@ sv/sdec_decode.sv @@
module sdec_decode
  import sdec_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  h_rows_t           h_rows,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [BYTE_W-1:0] parity_byte,
  output logic [BYTE_W-1:0] corrected_byte
);

  localparam int CW_BITS = 2 * DATA_BITS;

  logic [CW_BITS-1:0]   cw;
  logic [DATA_BITS-1:0] syn;
  logic [DATA_BITS-1:0] cols      [CW_BITS];
  logic [CW_BITS-1:0]   pair_hit  [CW_BITS];
  logic [CW_BITS-1:0]   pair_first[CW_BITS];
  logic [CW_BITS-1:0]   row_any;
  logic [CW_BITS-1:0]   row_first;
  logic [CW_BITS-1:0]   pair_mask;
  logic [CW_BITS-1:0]   single_hit;
  logic [CW_BITS-1:0]   single_first;
  logic [CW_BITS-1:0]   flip;
  logic [CW_BITS-1:0]   cw_fixed;

  // Codeword assembly: the MSB of each word is the lowest position.
  always_comb begin
    cw = '0;
    for (int p = 0; p < DATA_BITS; p++) begin
      cw[p]           = data_byte[DATA_BITS-1-p];
      cw[p+DATA_BITS] = parity_byte[DATA_BITS-1-p];
    end
  end

  // Syndrome and matrix columns.
  always_comb begin
    for (int r = 0; r < DATA_BITS; r++) begin
      syn[r] = ^(h_rows[r][CW_BITS-1:0] & cw);
    end
    for (int p = 0; p < CW_BITS; p++) begin
      for (int r = 0; r < DATA_BITS; r++) begin
        cols[p][r] = h_rows[r][p];
      end
    end
  end

  // Pair compares, all in parallel; only j above i counts.
  always_comb begin
    for (int i = 0; i < CW_BITS; i++) begin
      for (int j = 0; j < CW_BITS; j++) begin
        pair_hit[i][j] = (j > i) && ((cols[i] ^ cols[j]) == syn);
      end
      row_any[i]    = |pair_hit[i];
      pair_first[i] = pair_hit[i] & (~pair_hit[i] + CW_BITS'(1));
    end
    // The lowest i with any hit wins, and within it the lowest j.
    row_first = row_any & (~row_any + CW_BITS'(1));
    pair_mask = '0;
    for (int i = 0; i < CW_BITS; i++) begin
      if (row_first[i]) begin
        pair_mask = pair_mask | pair_first[i] | (CW_BITS'(1) << i);
      end
    end
  end

  // Single column compares; the lowest matching position wins.
  always_comb begin
    for (int p = 0; p < CW_BITS; p++) begin
      single_hit[p] = (cols[p] == syn);
    end
    single_first = single_hit & (~single_hit + CW_BITS'(1));
  end

  // Both corrections apply to the same word; a clean word passes through.
  assign flip     = (syn != '0) ? (pair_mask ^ single_first) : '0;
  assign cw_fixed = cw ^ flip;

  // Data half back to byte order, left aligned.
  always_comb begin
    corrected_byte = '0;
    for (int p = 0; p < DATA_BITS; p++) begin
      corrected_byte[BYTE_W-1-p] = cw_fixed[p];
    end
  end

endmodule

@@ sv/sdec_checker.sv @@
`include "assert_macros.svh"

module sdec_checker
  import sdec_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_corrected_byte
);

  localparam logic [BYTE_W-1:0] LOW_MASK = BYTE_W'({BYTE_W{1'b1}} >> DATA_BITS);

  // A stalled result stays offered and unchanged.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_corrected_byte), "result changed under stall")

  // The input only stalls when a finished result is blocked downstream.
  `ASSERT_CLK(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without back pressure")

  // Positions beyond the data word never appear in the result.
  `ASSERT_CLK(a_low_bits_zero, out_valid |-> (out_corrected_byte & LOW_MASK) == '0, "unused result bits set")

  // Reset empties the result register.
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind syndrome_double_error_corrector_core sdec_checker #(
  .DATA_BITS (DATA_BITS)
) u_sdec_checker (.*);

@@ bench/sdec_result_monitor.sv @@
module sdec_result_monitor
  import sdec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [BYTE_W-1:0]     in_parity_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [BYTE_W-1:0]     out_corrected_byte,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    words_in_flight,
  output int                    mismatch_count
);

  localparam int W = DATA_BITS_DEF;

  // Shadow copy of the parity-check rows, tracked from register writes.
  h_rows_t           h_rows;
  logic [BYTE_W-1:0] expected_bytes[$];

  // Decodes one received word against the shadow rows: syndrome, then the
  // pair search and the single-column search, both against that syndrome.
  function automatic logic [BYTE_W-1:0] correct_word(input logic [BYTE_W-1:0] data_b,
                                                     input logic [BYTE_W-1:0] parity_b);
    logic [2*W-1:0]    cw;
    logic [W-1:0]      syn;
    logic [W-1:0]      col[2*W];
    logic [BYTE_W-1:0] res;
    bit                hit;
    cw  = '0;
    syn = '0;
    res = '0;
    for (int p = 0; p < W; p++) begin
      cw[p]     = data_b[W-1-p];
      cw[p + W] = parity_b[W-1-p];
    end
    for (int r = 0; r < W; r++) begin
      syn[r] = ^(h_rows[r][2*W-1:0] & cw);
    end
    for (int p = 0; p < 2 * W; p++) begin
      for (int r = 0; r < W; r++) begin
        col[p][r] = h_rows[r][p];
      end
    end
    if (syn != '0) begin
      // First pair of columns whose XOR matches flips both positions.
      hit = 1'b0;
      for (int i = 0; i < 2 * W - 1 && !hit; i++) begin
        for (int j = i + 1; j < 2 * W && !hit; j++) begin
          if ((col[i] ^ col[j]) == syn) begin
            cw[i] = ~cw[i];
            cw[j] = ~cw[j];
            hit   = 1'b1;
          end
        end
      end
      // First single column that matches flips its position.
      hit = 1'b0;
      for (int p = 0; p < 2 * W && !hit; p++) begin
        if (col[p] == syn) begin
          cw[p] = ~cw[p];
          hit   = 1'b1;
        end
      end
    end
    for (int p = 0; p < W; p++) begin
      res[BYTE_W-1-p] = cw[p];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("%0t: corrected_byte %s: got %02h, expected %02h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Input transfers queue a prediction; result transfers are compared in order.
  always @(posedge clk) begin : watch
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      h_rows = '0;
      expected_bytes.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_bytes.push_back(correct_word(in_data_byte, in_parity_byte));
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("with no word outstanding", out_corrected_byte, '0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_corrected_byte !== want) begin
            report_mismatch("differs", out_corrected_byte, want);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        h_rows[paddr[APB_ADDR_W-1:2]] = pwdata[ROW_W-1:0];
      end
    end
    words_in_flight <= expected_bytes.size();
  end

endmodule

@@ bench/syndrome_double_error_corrector_core_tb.sv @@
module syndrome_double_error_corrector_core_tb;
  import sdec_pkg::*;

  localparam int W             = DATA_BITS_DEF;
  localparam int WORDS_PER_SET = 145;
  localparam int HOLD_CYCLES   = 80;
  localparam int NUM_SETS      = 8;

  typedef enum int {MX_ONES, MX_SYSTEMATIC, MX_STRIPES, MX_RANDOM, MX_ZERO, MX_SPARSE}
    matrix_kind_t;

  // Systematic code: identity over the parity positions, fixed data columns.
  localparam h_rows_t H_FIXED = {16'h80F4, 16'h407A, 16'h203D, 16'h109E,
                                 16'h084F, 16'h04A7, 16'h02D3, 16'h01E9};
  // Columns where some syndromes match no pair and others no single column.
  localparam h_rows_t H_NO_MATCH = {{6{16'h0000}}, 16'h0001, 16'hFFFF};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte;
  logic [BYTE_W-1:0]     in_parity_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_corrected_byte;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    words_in_flight;
  int                    mismatch_count;

  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_left   = 0;
  bit           hold_req    = 1'b0;
  bit           hold_ack    = 1'b0;
  h_rows_t      h_cur;
  matrix_kind_t set_kinds[NUM_SETS] = '{MX_ONES, MX_SYSTEMATIC, MX_STRIPES, MX_RANDOM,
                                        MX_SYSTEMATIC, MX_ZERO, MX_SPARSE, MX_SYSTEMATIC};

  always #5 clk = ~clk;

  syndrome_double_error_corrector_core dut (.*);

  sdec_result_monitor u_monitor (.*);

  // Watchdog for a hung run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall, with an occasional long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Syndrome of a word under the rows currently programmed.
  function automatic logic [W-1:0] syndrome_of(input logic [BYTE_W-1:0] d,
                                               input logic [BYTE_W-1:0] p);
    logic [2*W-1:0] cw;
    logic [W-1:0]   syn;
    for (int k = 0; k < W; k++) begin
      cw[k]     = d[W-1-k];
      cw[k + W] = p[W-1-k];
    end
    for (int r = 0; r < W; r++) begin
      syn[r] = ^(h_cur[r][2*W-1:0] & cw);
    end
    return syn;
  endfunction

  function automatic h_rows_t make_matrix(input matrix_kind_t kind);
    h_rows_t m;
    for (int r = 0; r < NUM_ROWS; r++) begin
      case (kind)
        MX_ONES:       m[r] = 16'hFFFF;
        MX_SYSTEMATIC: m[r] = (16'h1 << (W + r)) | 16'($urandom_range(255));
        MX_STRIPES:    m[r] = r[0] ? 16'h5555 : 16'hAAAA;
        MX_RANDOM:     m[r] = 16'($urandom_range(65535));
        MX_SPARSE:     m[r] = (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
        default:       m[r] = 16'h0000;
      endcase
    end
    return m;
  endfunction

  // Programs all eight rows, each write with a setup phase and then an access phase.
  task automatic write_matrix(input h_rows_t m);
    for (int r = 0; r < NUM_ROWS; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_W'(r * 4);
      pwdata  <= {{(APB_DATA_W - ROW_W){1'b0}}, m[r]};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    h_cur = m;
  endtask

  // Offers one word, with a random gap first, and waits for its transfer.
  task automatic send_word(input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] p);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_parity_byte <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the codeword for d with the positions in flips inverted. Where the
  // rows admit no codeword for d, the parity is random instead.
  task automatic send_coded(input logic [BYTE_W-1:0] d, input logic [2*W-1:0] flips);
    logic [BYTE_W-1:0] p;
    bit                found;
    found = 1'b0;
    p     = 8'($urandom_range(255));
    for (int c = 0; c < 256 && !found; c++) begin
      if (syndrome_of(d, 8'(c)) == '0) begin
        p     = 8'(c);
        found = 1'b1;
      end
    end
    for (int k = 0; k < 2 * W; k++) begin
      if (flips[k]) begin
        if (k < W) d[W-1-k] = ~d[W-1-k];
        else p[2*W-1-k] = ~p[2*W-1-k];
      end
    end
    send_word(d, p);
  endtask

  // Mostly codewords with zero, one or two errors; the rest pure noise.
  task automatic send_random();
    int             kind;
    int             pos1;
    int             pos2;
    logic [2*W-1:0] flips;
    kind  = $urandom_range(99);
    pos1  = $urandom_range(2 * W - 1);
    pos2  = (pos1 + 1 + $urandom_range(2 * W - 2)) % (2 * W);
    flips = '0;
    if (kind < 10) begin
      send_word(8'($urandom_range(255)), 8'($urandom_range(255)));
    end else begin
      if (kind >= 40) flips[pos1] = 1'b1;
      if (kind >= 70) flips[pos2] = 1'b1;
      send_coded(8'($urandom_range(255)), flips);
    end
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= '0;
    in_parity_byte <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    h_cur = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rows at reset: the syndrome is always zero and words pass unchanged.
    send_word(8'h00, 8'h00);
    send_word(8'hFF, 8'hFF);
    send_word(8'h80, 8'h01);
    send_word(8'h01, 8'h80);
    drain();

    // All-ones rows: odd weight gives an all-ones syndrome, no pair matches.
    write_matrix('1);
    send_word(8'hFF, 8'h00);
    send_word(8'hFE, 8'h00);
    send_word(8'h00, 8'h01);
    send_word(8'h00, 8'h00);
    drain();

    // Systematic code: clean word, single and double errors, heavy damage.
    write_matrix(H_FIXED);
    send_coded(8'h5A, 16'h0000);
    send_coded(8'h5A, 16'h0001);
    send_coded(8'h5A, 16'h0100);
    send_coded(8'h5A, 16'h0003);
    send_coded(8'hC3, 16'h8001);
    send_coded(8'h00, 16'hFFFF);
    send_coded(8'hFF, 16'h0000);
    drain();

    // Syndromes that one search or the other cannot match.
    write_matrix(H_NO_MATCH);
    send_word(8'h80, 8'h80);
    send_word(8'h40, 8'h00);
    send_word(8'hC0, 8'hFF);
    drain();

    // Random sets, each under its own rows, with an idling pattern per group of sets.
    for (int s = 0; s < NUM_SETS; s++) begin
      write_matrix(make_matrix(set_kinds[s]));
      if (s < 3) begin
        tx_idle_pct = 17;
        rx_idle_pct <= 85;
      end else if (s < 6) begin
        tx_idle_pct = 85;
        rx_idle_pct <= 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        if (s == 1 && n == 40) hold_req <= ~hold_req;
        if (s == 4 && n == 70) drain();
        send_random();
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
